// File: hdl/complex_fir_lowpass_filter_macros.svh
// Assertion macros for the complex low-pass FIR.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef COMPLEX_FIR_LOWPASS_FILTER_MACROS_SVH
`define COMPLEX_FIR_LOWPASS_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define CFLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cflp: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define CFLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cflp: next-cycle check failed");
`else
`define CFLP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/cflp_pkg.sv
// Shared constants, types and helper functions of the complex low-pass FIR.
// No dependencies; imported by every module of the block.
package cflp_pkg;

    localparam int TAPS        = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int ALPHA_W     = 16;
    localparam int ALPHA_RESET = 73;
    localparam int FRAC_BITS   = 15;
    localparam int ONE_Q15     = 1 << FRAC_BITS;

    // Only taps 0 .. TAPS/2 carry a weight; the taps above them are not used.
    localparam int LAST_TAP = TAPS / 2;
    localparam int ADDR_W   = $clog2(TAPS);
    localparam int TAP_W    = $clog2(LAST_TAP + 1);
    localparam int W_W      = FRAC_BITS + 2;
    localparam int PROD_W   = W_W + 1 + SAMPLE_BITS;
    localparam int ACC_W    = PROD_W + TAP_W;
    localparam int SH_W     = ACC_W - FRAC_BITS;
    localparam int HIST_W   = 2 * SAMPLE_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [W_W-1:0]         t_weight;
    typedef logic        [ADDR_W-1:0]      t_addr;
    typedef logic        [TAP_W-1:0]       t_tap;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [SH_W-1:0]        t_shifted;

    localparam t_addr    FILL_MAX = t_addr'(TAPS - 1);
    localparam t_tap     TAP_LAST = t_tap'(LAST_TAP);
    localparam t_weight  W_ONE    = t_weight'(ONE_Q15);
    localparam t_shifted SAT_MAX  = t_shifted'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam t_shifted SAT_MIN  = t_shifted'(-(longint'(1) << (SAMPLE_BITS - 1)));

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Control word from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clr;
        logic en;
        logic last;
    } t_mac_ctl;

    // Alpha above one is limited to one, so the middle tap stays non-negative.
    function automatic t_weight clamp_alpha(input logic [ALPHA_W-1:0] v);
        t_weight w;
        w = t_weight'(v);
        if (w > W_ONE) begin
            w = W_ONE;
        end
        return w;
    endfunction

    // Lower half of the taps weighs alpha, the middle tap one minus alpha.
    function automatic t_weight tap_weight(input t_tap tap, input t_weight a);
        t_weight w;
        if (tap < TAP_LAST) begin
            w = a;
        end else begin
            w = W_ONE - a;
        end
        return w;
    endfunction

    // Arithmetic shift right by the fraction bits, then saturate.
    function automatic t_sample sat_q15(input t_acc acc);
        t_shifted sh;
        t_sample  r;
        sh = acc[ACC_W-1:FRAC_BITS];
        if (sh > SAT_MAX) begin
            r = t_sample'(SAT_MAX);
        end else if (sh < SAT_MIN) begin
            r = t_sample'(SAT_MIN);
        end else begin
            r = t_sample'(sh);
        end
        return r;
    endfunction

endpackage

// File: hdl/cflp_hist.sv
// Sample history memory: one write port, one read port with registered data.
// Depends on cflp_pkg.
module cflp_hist (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  cflp_pkg::t_addr                  i_waddr,
    input  logic [cflp_pkg::HIST_W-1:0]      i_wdata,
    input  cflp_pkg::t_addr                  i_raddr,
    output logic [cflp_pkg::HIST_W-1:0]      o_rdata
);
    import cflp_pkg::*;

    logic [HIST_W-1:0] r_mem [TAPS];
    logic [HIST_W-1:0] r_rdata;

    // Write the new sample and read one tap per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/cflp_mac.sv
// Shared multiply-accumulate unit for the I and Q paths.
// Depends on cflp_pkg; driven by the sequencer in the top level.
module cflp_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cflp_pkg::t_mac_ctl   i_ctl,
    input  cflp_pkg::t_weight    i_weight,
    input  cflp_pkg::t_sample    i_x_i,
    input  cflp_pkg::t_sample    i_x_q,
    output cflp_pkg::t_acc       o_acc_i,
    output cflp_pkg::t_acc       o_acc_q,
    output logic                 o_done
);
    import cflp_pkg::*;

    logic  r_prod_vld;
    logic  r_prod_last;
    logic  r_done;
    t_prod r_prod_i;
    t_prod r_prod_q;
    t_acc  r_acc_i;
    t_acc  r_acc_q;
    t_prod n_prod_i;
    t_prod n_prod_q;

    // The weight is unsigned, so it gets a zero sign bit.
    assign n_prod_i = $signed({1'b0, i_weight}) * i_x_i;
    assign n_prod_q = $signed({1'b0, i_weight}) * i_x_q;

    // Control flags of the product stage and the done flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld  <= 1'b0;
            r_prod_last <= 1'b0;
            r_done      <= 1'b0;
        end else if (i_ctl.clr) begin
            r_prod_vld  <= 1'b0;
            r_prod_last <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_prod_vld  <= i_ctl.en;
            r_prod_last <= i_ctl.en & i_ctl.last;
            if (r_prod_vld && r_prod_last) begin
                r_done <= 1'b1;
            end
        end
    end

    // Product register, then accumulation.
    always_ff @(posedge i_clk) begin
        r_prod_i <= n_prod_i;
        r_prod_q <= n_prod_q;
        if (i_ctl.clr) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_prod_vld) begin
            r_acc_i <= r_acc_i + ACC_W'(r_prod_i);
            r_acc_q <= r_acc_q + ACC_W'(r_prod_q);
        end
    end

    assign o_acc_i = r_acc_i;
    assign o_acc_q = r_acc_q;
    assign o_done  = r_done;

endmodule

// File: hdl/complex_fir_lowpass_filter.sv
// Complex low-pass FIR: each accepted word is one I/Q sample, and from the 32nd
// sample of a block on, every sample yields one filtered I/Q word.
// A sample with no result leaves the block ready; one with a result stalls the
// input while the shared multiply-accumulate unit walks the 17 weighted taps
// one per cycle behind a registered history read and a product register, then
// until the output register is free. A finished word waits in an output
// register, so the next sample is taken while it is stalled downstream; a
// second word waits until the first has left. Alpha is to be written through
// i_cfg_we/i_cfg_data only while the block is idle, which is not enforced.
// Depends on cflp_pkg, cflp_hist, cflp_mac and the assertion macro header.
`include "complex_fir_lowpass_filter_macros.svh"
module complex_fir_lowpass_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cflp_pkg::ALPHA_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_block_start,
    input  cflp_pkg::t_sample             i_sample_i,
    input  cflp_pkg::t_sample             i_sample_q,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cflp_pkg::t_sample             o_out_i,
    output cflp_pkg::t_sample             o_out_q
);
    import cflp_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [ALPHA_W-1:0]  r_alpha;
    t_addr               r_wslot;
    t_addr               r_fill;
    t_addr               r_base;
    t_tap                r_tap;
    logic                r_rd_vld;
    logic                r_rd_last;
    t_weight             r_rd_weight;
    logic                r_out_valid;
    t_sample             r_out_i;
    t_sample             r_out_q;

    logic                in_acc;
    logic                emit;
    t_addr               eff_fill;
    logic                issue;
    logic                load_out;
    logic                out_free;
    logic [ADDR_W:0]     rd_diff;
    t_addr               raddr;
    logic [HIST_W-1:0]   rdata;
    t_mac_ctl            mac_ctl;
    t_acc                acc_i;
    t_acc                acc_q;
    logic                mac_done;

    // Handshake and block fill bookkeeping.
    assign in_acc   = i_in_valid & ~o_in_stall;
    assign eff_fill = i_block_start ? '0 : r_fill;
    assign emit     = (eff_fill == FILL_MAX);
    assign out_free = ~r_out_valid | ~i_out_stall;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && emit) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_tap == TAP_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_RUN:   issue      = 1'b1;
            ST_DRAIN: load_out   = mac_done & out_free;
            default:  o_in_stall = 1'b1;
        endcase
    end

    // Read address walks backward from the newest sample, wrapping.
    assign rd_diff = {1'b0, r_base} - (ADDR_W+1)'(r_tap);
    always_comb begin
        if (rd_diff[ADDR_W]) begin
            raddr = t_addr'(rd_diff + (ADDR_W+1)'(TAPS));
        end else begin
            raddr = t_addr'(rd_diff);
        end
    end

    // Control registers: state, alpha, slot and fill counters, tap counter, read flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_alpha   <= ALPHA_W'(ALPHA_RESET);
            r_wslot   <= '0;
            r_fill    <= '0;
            r_tap     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= issue;
            r_rd_last <= issue & (r_tap == TAP_LAST);
            if (i_cfg_we) begin
                r_alpha <= i_cfg_data;
            end
            if (in_acc) begin
                r_wslot <= (r_wslot == FILL_MAX) ? '0 : r_wslot + 1'b1;
                r_fill  <= (eff_fill == FILL_MAX) ? FILL_MAX : eff_fill + 1'b1;
                r_tap   <= '0;
            end else if (issue) begin
                r_tap   <= r_tap + 1'b1;
            end
        end
    end

    // Newest slot and the weight of the tap being read.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_base <= r_wslot;
        end
        r_rd_weight <= tap_weight(r_tap, clamp_alpha(r_alpha));
    end

    // Output register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_i <= sat_q15(acc_i);
            r_out_q <= sat_q15(acc_q);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_i     = r_out_i;
    assign o_out_q     = r_out_q;

    // History memory holds I in the upper half, Q in the lower half.
    cflp_hist u_hist (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wslot),
        .i_wdata ({i_sample_i, i_sample_q}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Multiply-accumulate control from the sequencer.
    assign mac_ctl.clr  = in_acc & emit;
    assign mac_ctl.en   = r_rd_vld;
    assign mac_ctl.last = r_rd_last;

    cflp_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_weight (r_rd_weight),
        .i_x_i    (rdata[HIST_W-1:SAMPLE_BITS]),
        .i_x_q    (rdata[SAMPLE_BITS-1:0]),
        .o_acc_i  (acc_i),
        .o_acc_q  (acc_q),
        .o_done   (mac_done)
    );

    // The last product cannot land while taps are still being issued.
    `CFLP_ASSERT_IMP(a_no_done_in_run, i_clk, i_rst_n, r_state == ST_RUN, !mac_done)
    // A sample that completes a full window starts the tap walk.
    `CFLP_ASSERT_NEXT(a_emit_runs, i_clk, i_rst_n, in_acc && emit, r_state == ST_RUN)
    // A sample that yields no result leaves the block ready.
    `CFLP_ASSERT_NEXT(a_skip_idle, i_clk, i_rst_n, in_acc && !emit, r_state == ST_IDLE)
    // The tap counter never passes the middle tap while issuing.
    `CFLP_ASSERT_IMP(a_tap_bound, i_clk, i_rst_n, r_state == ST_RUN, r_tap <= TAP_LAST)

endmodule

// File: tb/complex_fir_lowpass_filter_tb.sv
// Testbench for the complex low-pass FIR: sends I/Q sample words, predicts each
// filtered word with a model of its own and checks every output word in order.
// Depends on cflp_pkg and the complex_fir_lowpass_filter top level.
module complex_fir_lowpass_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cflp_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS  = 600;
    localparam int MAX_PRINTS    = 30;
    localparam int MAX_GAP       = 30;

    typedef struct {
        t_sample re;
        t_sample im;
    } t_iq_word;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [ALPHA_W-1:0] i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_block_start = 1'b0;
    t_sample            i_sample_i    = '0;
    t_sample            i_sample_q    = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    t_sample            o_out_i;
    t_sample            o_out_q;

    // Filter model state: sample history, write pointer, block fill and alpha.
    t_sample            hist_re [TAPS];
    t_sample            hist_im [TAPS];
    int                 next_slot   = 0;
    int                 block_fill  = 0;
    logic [ALPHA_W-1:0] alpha_model = ALPHA_W'(ALPHA_RESET);

    t_iq_word filtered_words [$];
    int       mismatches    = 0;
    int       sent_words    = 0;
    int       cycle_count   = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;
    int       holdoff_left  = 0;
    bit       offering      = 1'b0;

    complex_fir_lowpass_filter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_block_start (i_block_start),
        .i_sample_i    (i_sample_i),
        .i_sample_q    (i_sample_q),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_i       (o_out_i),
        .o_out_q       (o_out_q)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Shift the Q1.15-weighted sum down with floor rounding and clip to the sample range.
    function automatic t_sample scale_and_clip(input longint acc);
        longint hi;
        longint lo;
        longint v;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        v  = acc >>> FRAC_BITS;
        if (v > hi) begin
            v = hi;
        end else if (v < lo) begin
            v = lo;
        end
        return t_sample'(v);
    endfunction

    // Store one accepted sample and queue the filtered word it yields, if any.
    task automatic filter_sample(input logic start, input t_sample re, input t_sample im);
        longint   a;
        longint   w;
        longint   acc_re;
        longint   acc_im;
        int       slot;
        t_iq_word word;
        if (start) begin
            block_fill = 0;
        end
        hist_re[next_slot] = re;
        hist_im[next_slot] = im;
        if (block_fill == TAPS - 1) begin
            a      = (alpha_model > ONE_Q15) ? longint'(ONE_Q15) : longint'(alpha_model);
            acc_re = 0;
            acc_im = 0;
            for (int j = 0; j <= TAPS / 2; j++) begin
                slot   = (next_slot + TAPS - j) % TAPS;
                w      = (j < TAPS / 2) ? a : longint'(ONE_Q15) - a;
                acc_re += w * longint'(hist_re[slot]);
                acc_im += w * longint'(hist_im[slot]);
            end
            word.re = scale_and_clip(acc_re);
            word.im = scale_and_clip(acc_im);
            filtered_words.push_back(word);
        end
        next_slot = (next_slot + 1) % TAPS;
        if (block_fill < TAPS - 1) begin
            block_fill++;
        end
    endtask

    // Sample values weighted toward the extremes and toward small magnitudes.
    function automatic t_sample rand_sample();
        t_sample s;
        case ($urandom_range(9))
            0: begin
                s = t_sample'(16'sh7FFF);
            end
            1: begin
                s = t_sample'(16'sh8000);
            end
            2: begin
                s = t_sample'(int'($urandom_range(64)) - 32);
            end
            default: begin
                s = t_sample'($urandom);
            end
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    // Offer one word, with a random idle gap before it, and wait until it is taken.
    task automatic send_word(input logic start, input t_sample re, input t_sample im);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            if (offering) begin
                i_in_valid <= 1'b0;
            end
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_block_start <= start;
        i_sample_i    <= re;
        i_sample_q    <= im;
        offering      = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        filter_sample(start, re, im);
        sent_words++;
    endtask

    task automatic stop_sending();
        if (offering) begin
            i_in_valid <= 1'b0;
        end
        offering = 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results_done();
        while (filtered_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Alpha is only written once the block has finished all its work.
    task automatic write_alpha(input logic [ALPHA_W-1:0] value);
        stop_sending();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        alpha_model = value;
        i_cfg_we   <= 1'b0;
    endtask

    // Random well-formed blocks, mostly long enough to produce words, plus
    // short blocks and loose words with a random block_start.
    task automatic send_random_block();
        int kind;
        int len;
        kind = $urandom_range(99);
        if (kind < 75) begin
            len = $urandom_range(70, TAPS);
        end else if (kind < 90) begin
            len = $urandom_range(TAPS - 1, 1);
        end else begin
            len = 0;
        end
        if (len > 0) begin
            send_word(1'b1, rand_sample(), rand_sample());
            repeat (len - 1) send_word(1'b0, rand_sample(), rand_sample());
        end else begin
            repeat ($urandom_range(20, 1)) begin
                send_word(1'($urandom_range(1)), rand_sample(), rand_sample());
            end
        end
    endtask

    // A block shorter than the tap count yields nothing; a restart keeps the history.
    task automatic test_short_block();
        send_word(1'b1, 16'sh7FFF, 16'sh8000);
        send_word(1'b0, 16'sh8000, 16'sh7FFF);
        send_word(1'b0, 16'sh0000, -16'sh0001);
        send_word(1'b0, -16'sh0001, 16'sh0000);
        send_word(1'b1, 16'sh5555, 16'shAAAA);
        send_word(1'b0, 16'shAAAA, 16'sh5555);
    endtask

    // Fill a block with full-scale words at the reset alpha; the sums overflow.
    task automatic test_full_scale_block();
        send_word(1'b1, 16'sh7FFF, 16'sh8000);
        repeat (TAPS - 1) send_word(1'b0, 16'sh7FFF, 16'sh8000);
        send_word(1'b0, 16'sh8000, 16'sh7FFF);
        send_word(1'b0, 16'sh0000, -16'sh0001);
    endtask

    // Corner alphas on a full block, including all ones above the Q1.15 one.
    task automatic test_alpha_corners();
        logic [ALPHA_W-1:0] corners [5];
        corners = '{16'h0000, 16'h8000, 16'hFFFF, 16'h0001, 16'h4000};
        foreach (corners[k]) begin
            write_alpha(corners[k]);
            send_word(1'b0, 16'sh7FFF, 16'sh8000);
            send_word(1'b0, 16'sh8000, 16'sh7FFF);
        end
        // A restart in a full block silences the output again.
        send_word(1'b1, 16'sh1234, -16'sh1234);
        send_word(1'b0, -16'sh0001, 16'sh0001);
    endtask

    // Random traffic in four phases of sender idling and receiver stalls, each with its own alpha.
    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 2) begin
                write_alpha(ALPHA_W'($urandom_range(65535)));
            end else begin
                write_alpha(ALPHA_W'($urandom_range(ONE_Q15)));
            end
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 52;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 52;
                end
                default: begin
                    send_idle_pct = 23;
                    stall_pct     = 23;
                end
            endcase
            target = sent_words + RANDOM_WORDS / 4;
            while (sent_words < target) begin
                send_random_block();
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // words, so the output register and the engine fill and the input stalls.
    task automatic test_output_holdoff();
        write_alpha(ALPHA_W'($urandom_range(ONE_Q15)));
        send_idle_pct = 0;
        stall_pct     = 0;
        holdoff_left  = 300;
        send_word(1'b1, rand_sample(), rand_sample());
        repeat (79) send_word(1'b0, rand_sample(), rand_sample());
    endtask

    // The sender pauses inside a block until every pending word has come out.
    task automatic test_sender_pause();
        send_idle_pct = 0;
        stall_pct     = 23;
        send_word(1'b1, rand_sample(), rand_sample());
        repeat (TAPS + 4) send_word(1'b0, rand_sample(), rand_sample());
        repeat (5) begin
            stop_sending();
            wait_results_done();
            repeat (3) send_word(1'b0, rand_sample(), rand_sample());
        end
    endtask

    // Receiver stall: a requested hold-off first, random stalls otherwise.
    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            i_out_stall <= 1'b1;
            holdoff_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each accepted output word with the oldest predicted word.
    always @(posedge i_clk) begin : check_words
        t_iq_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filtered_words.size() == 0) begin
                report_mismatch("unexpected output word, out_i", o_out_i, 0);
            end else begin
                want = filtered_words.pop_front();
                if (o_out_i !== want.re) begin
                    report_mismatch("out_i mismatch", o_out_i, want.re);
                end
                if (o_out_q !== want.im) begin
                    report_mismatch("out_q mismatch", o_out_q, want.im);
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL complex_fir_lowpass_filter");
            $finish;
        end
    end

    initial begin
        foreach (hist_re[k]) begin
            hist_re[k] = '0;
            hist_im[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_block();
        test_full_scale_block();
        test_alpha_corners();
        test_random_traffic();
        test_output_holdoff();
        test_sender_pause();

        stop_sending();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS complex_fir_lowpass_filter");
        end else begin
            $display("FAIL complex_fir_lowpass_filter");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/cflp_pkg.sv
hdl/cflp_hist.sv
hdl/cflp_mac.sv
hdl/complex_fir_lowpass_filter.sv
tb/complex_fir_lowpass_filter_tb.sv
